// File: hdl/positional_list_store_macros.svh
// positional_list_store_macros.svh: assertion macros for the list store checker.
// Used by pls_checker.sv; expects signals named clock and reset in scope.
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("list store check failed");

// Consequent must hold in the cycle after the antecedent.
`define PLS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("list store check failed");

`endif

// File: hdl/pls_pkg.sv
// pls_pkg: field widths, default sizes and operation/status codes of the list store.
// No dependencies; used by the channel interfaces, the top level and the checker.
package pls_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths of the channels
   localparam int OPCODE_W   = 2;
   localparam int POSITION_W = 7;
   localparam int DATA_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_GET    = 2'd1,
      OP_SET    = 2'd2,
      OP_DELETE = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

// File: hdl/pls_req_if.sv
// pls_req_if: command channel of the list store (valid/ready plus command fields).
// Depends on pls_pkg for field widths.
interface pls_req_if;
   logic                            valid;
   logic                            ready;
   logic [pls_pkg::OPCODE_W-1:0]    opcode;
   logic [pls_pkg::POSITION_W-1:0]  position;
   logic [pls_pkg::DATA_W-1:0]      data_in;

   modport source (output valid, output opcode, output position, output data_in,
                   input ready);
   modport sink   (input valid, input opcode, input position, input data_in,
                   output ready);
   modport mon    (input valid, input ready, input opcode, input position,
                   input data_in);
endinterface

// File: hdl/pls_rsp_if.sv
// pls_rsp_if: result channel of the list store (valid/ready plus result fields).
// Depends on pls_pkg for field widths.
interface pls_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pls_pkg::DATA_W-1:0]      data_out;
   logic [pls_pkg::STATUS_W-1:0]    status;
   logic [pls_pkg::COUNT_W-1:0]     entry_count;

   modport source (output valid, output data_out, output status, output entry_count,
                   input ready);
   modport sink   (input valid, input data_out, input status, input entry_count,
                   output ready);
   modport mon    (input valid, input ready, input data_out, input status,
                   input entry_count);
endinterface

// File: hdl/positional_list_store.sv
// positional_list_store: bounded ordered list addressed by position, one result per item.
// Depends on pls_pkg, pls_req_if and pls_rsp_if.
//
//   channel   dir   fields                               accepted when
//   req_ch    in    opcode, position, data_in            valid && ready
//   rsp_ch    out   data_out, status, entry_count        valid && ready
//
// Range and full errors skip the entry memory; get and set read the addressed entry;
// insert and delete shift the moved entries one at a time. The shift speed is set by
// the entry memory: one read port and one write port move one entry per cycle.
// Reset is synchronous; it empties the list, entry contents are left as they are.
// A stalled result sits in the output register; the next item is taken meanwhile,
// and its result waits until the register is free.
module positional_list_store #(
   parameter int CAPACITY   = pls_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pls_req_if.sink    req_ch,
   pls_rsp_if.source  rsp_ch
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > pls_pkg::POSITION_W) ? CW : pls_pkg::POSITION_W;
   localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_READ_WAIT,
      S_SHIFT,
      S_DRAIN,
      S_PUT,
      S_DONE
   } state_type;

   // Entry memory: one write and one registered read per cycle
   logic [DATA_WIDTH-1:0] entry_mem_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   pls_pkg::opcode_type   op_ff, op_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [DATA_WIDTH-1:0] result_ff, result_in;
   pls_pkg::status_type   status_ff, status_in;
   logic [AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic                  pend_ff, pend_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   pls_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [CW-1:0]         rsp_count_ff, rsp_count_in;

   logic [CMPW-1:0]       pos_c;
   logic [CMPW-1:0]       cnt_c;
   logic [AW-1:0]         last_addr;
   logic                  dir_up;
   logic [AW-1:0]         rd_step;
   logic [AW-1:0]         wr_step;

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.data_out    = pls_pkg::DATA_W'(rsp_data_ff);
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_count = pls_pkg::COUNT_W'(rsp_count_ff);

   // Range checks against the current fill
   assign pos_c     = CMPW'(req_ch.position);
   assign cnt_c     = CMPW'(count_ff);
   assign last_addr = AW'(count_ff - CW'(1));

   // Pointer stepper: insert walks toward the front, delete toward the back
   assign dir_up  = (op_ff != pls_pkg::OP_INSERT);
   assign rd_step = dir_up ? AW'(rd_ptr_ff + AW'(1)) : AW'(rd_ptr_ff - AW'(1));
   assign wr_step = dir_up ? AW'(wr_ptr_ff + AW'(1)) : AW'(wr_ptr_ff - AW'(1));

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      result_in     = result_ff;
      status_in     = status_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      pend_in       = pend_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rd_addr       = rd_ptr_ff;
      mem_we        = 1'b0;
      mem_waddr     = wr_ptr_ff;
      mem_wdata     = rd_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in     = pls_pkg::opcode_type'(req_ch.opcode);
               pos_in    = AW'(req_ch.position);
               val_in    = DATA_WIDTH'(req_ch.data_in);
               result_in = '0;
               status_in = pls_pkg::ST_DONE;
               pend_in   = 1'b0;
               if (pls_pkg::opcode_type'(req_ch.opcode) == pls_pkg::OP_INSERT) begin
                  if (pos_c > cnt_c) begin
                     status_in = pls_pkg::ST_RANGE;
                     state_in  = S_DONE;
                  end else if (cnt_c >= CAP_C) begin
                     status_in = pls_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end else if (pos_c == cnt_c) begin
                     state_in = S_PUT;
                  end else begin
                     rd_ptr_in = last_addr;
                     wr_ptr_in = AW'(count_ff);
                     state_in  = S_SHIFT;
                  end
               end else if (pos_c >= cnt_c) begin
                  status_in = pls_pkg::ST_RANGE;
                  state_in  = S_DONE;
               end else begin
                  rd_ptr_in = AW'(req_ch.position);
                  state_in  = S_READ;
               end
            end
         end
         S_READ: begin
            // read of the addressed entry is in flight
            state_in = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            result_in = rd_data_ff;
            case (op_ff)
               pls_pkg::OP_SET: begin
                  mem_we    = 1'b1;
                  mem_waddr = pos_ff;
                  mem_wdata = val_ff;
                  state_in  = S_DONE;
               end
               pls_pkg::OP_DELETE: begin
                  if (pos_ff == last_addr) begin
                     count_in = count_ff - CW'(1);
                     state_in = S_DONE;
                  end else begin
                     rd_ptr_in = AW'(pos_ff + AW'(1));
                     wr_ptr_in = pos_ff;
                     pend_in   = 1'b0;
                     state_in  = S_SHIFT;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SHIFT: begin
            // read one entry, write the one read last cycle to its new place
            if (pend_ff) begin
               mem_we    = 1'b1;
               wr_ptr_in = wr_step;
            end
            pend_in = 1'b1;
            if ((!dir_up && rd_ptr_ff == pos_ff) || (dir_up && rd_ptr_ff == last_addr)) begin
               state_in = S_DRAIN;
            end else begin
               rd_ptr_in = rd_step;
            end
         end
         S_DRAIN: begin
            mem_we  = 1'b1;
            pend_in = 1'b0;
            if (dir_up) begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end else begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = val_ff;
            count_in  = count_ff + CW'(1);
            result_in = val_ff;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // hand the item to the output register once it is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = result_ff;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      result_ff     <= result_in;
      status_ff     <= status_in;
      rd_ptr_ff     <= rd_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Entry memory ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

endmodule

// File: hdl/pls_checker.sv
// pls_checker: port-level checks of the list store, bound to positional_list_store.
// Depends on pls_pkg and positional_list_store_macros.svh.
`include "positional_list_store_macros.svh"

module pls_checker #(
   parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [pls_pkg::DATA_W-1:0]     rsp_data_out,
   input logic [pls_pkg::STATUS_W-1:0]   rsp_status,
   input logic [pls_pkg::COUNT_W-1:0]    rsp_entry_count
);

   localparam int RSP_W = pls_pkg::DATA_W + pls_pkg::STATUS_W + pls_pkg::COUNT_W;
   localparam logic [pls_pkg::COUNT_W-1:0] FULL_COUNT = pls_pkg::COUNT_W'(CAPACITY);

   logic [RSP_W-1:0] rsp_word;
   logic             rsp_err;
   logic             rsp_full;

   assign rsp_word = {rsp_data_out, rsp_status, rsp_entry_count};
   assign rsp_err  = rsp_valid && (rsp_status != pls_pkg::ST_DONE);
   assign rsp_full = rsp_valid && (rsp_status == pls_pkg::ST_FULL);

   // a stalled result holds
   `PLS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // one item at a time: busy right after an accept
   `PLS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

   // failed items return zero data
   `PLS_ASSERT_SAME(a_err_zero, rsp_err, rsp_data_out == '0)

   // a full report only comes with the store at capacity
   `PLS_ASSERT_SAME(a_full_count, rsp_full, rsp_entry_count == FULL_COUNT)

endmodule

bind positional_list_store pls_checker #(.CAPACITY(CAPACITY)) u_pls_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_data_out    (rsp_ch.data_out),
   .rsp_status      (rsp_ch.status),
   .rsp_entry_count (rsp_ch.entry_count)
);
